[design/fbpa_pkg.sv]
// Package for the fixed block pool allocator: sizes, codes and the structs
// passed between the top level and the slab unit. No dependencies.
`timescale 1ns / 1ps

package fbpa_pkg;

   // Sizing of the pool.
   localparam int FREE_DEPTH = 1024;
   localparam int MAX_SLABS  = 8;
   localparam int ADDR_BITS  = 20;

   localparam int FREE_IDX_W = $clog2(FREE_DEPTH);
   localparam int FREE_CNT_W = $clog2(FREE_DEPTH + 1);
   localparam int SLAB_IDX_W = (MAX_SLABS > 1) ? $clog2(MAX_SLABS) : 1;
   localparam int SLAB_CNT_W = $clog2(MAX_SLABS + 1);

   // Field widths of the ports.
   localparam int OP_W      = 2;
   localparam int STATUS_W  = 2;
   localparam int BLOCK_W   = 13;
   localparam int INIT_W    = 20;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = 20;

   // Register reset values.
   localparam logic [BLOCK_W-1:0] BLOCK_BYTES_RESET   = BLOCK_W'(16);
   localparam logic [INIT_W-1:0]  INITIAL_BYTES_RESET = INIT_W'(1024);

   localparam logic [ADDR_BITS-1:0] ADDR_MAX = {ADDR_BITS{1'b1}};

   // Operation codes of a request.
   localparam logic [OP_W-1:0] OP_GET  = 2'd0;
   localparam logic [OP_W-1:0] OP_PUT  = 2'd1;
   localparam logic [OP_W-1:0] OP_GROW = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_BYTES   = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INITIAL_BYTES = 1'd1;

   // Response status codes.
   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK          = 2'd0,
      STATUS_EMPTY       = 2'd1,
      STATUS_STORE_FULL  = 2'd2,
      STATUS_GROW_REJECT = 2'd3
   } status_type;

   // Request sequencer states.
   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } fsm_state_type;

   // Command from the top level to the slab unit.
   typedef struct packed {
      logic                 bump;
      logic                 grow;
      logic [ADDR_BITS-1:0] new_total;
   } slab_cmd_type;

   // Answer of the slab unit for the command presented.
   typedef struct packed {
      logic                 empty;
      logic                 grow_reject;
      logic [ADDR_BITS-1:0] addr;
   } slab_rsp_type;

endpackage

[design/fbpa_slab.sv]
// Slab unit of the fixed block pool allocator: slab limits, bump pointer and
// grow handling. Depends on fbpa_pkg.
`timescale 1ns / 1ps

module fbpa_slab (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          restart,
   input  logic [fbpa_pkg::INIT_W-1:0]   restart_bytes,
   input  logic [fbpa_pkg::BLOCK_W-1:0]  block_bytes,
   input  fbpa_pkg::slab_cmd_type        cmd,
   output fbpa_pkg::slab_rsp_type        rsp
);
   import fbpa_pkg::*;

   logic [ADDR_BITS-1:0]  slab_limit_ff [MAX_SLABS];
   logic [ADDR_BITS-1:0]  slab_limit_in [MAX_SLABS];
   logic [SLAB_CNT_W-1:0] slab_count_ff, slab_count_in;
   logic [SLAB_IDX_W-1:0] current_slab_ff, current_slab_in;
   logic [ADDR_BITS-1:0]  bump_pos_ff, bump_pos_in;
   logic [ADDR_BITS-1:0]  pool_bytes_ff, pool_bytes_in;

   logic [BLOCK_W-1:0]    blk;
   logic [ADDR_BITS-1:0]  lim;
   logic [ADDR_BITS:0]    bump_end;
   logic                  exhausted;
   logic                  last_slab;
   logic [ADDR_BITS-1:0]  base;
   logic [ADDR_BITS:0]    next_pos;
   logic [ADDR_BITS-1:0]  start_bytes;

   // A zero block size counts as one byte.
   assign blk = (block_bytes == '0) ? BLOCK_W'(1) : block_bytes;

   // Exhaustion check on the current slab and the start of the block.
   assign lim       = slab_limit_ff[current_slab_ff];
   assign bump_end  = {1'b0, bump_pos_ff} + (ADDR_BITS + 1)'(blk);
   assign exhausted = bump_end > {1'b0, lim};
   assign last_slab = ((SLAB_CNT_W + 1)'(current_slab_ff) + (SLAB_CNT_W + 1)'(1))
                      >= (SLAB_CNT_W + 1)'(slab_count_ff);
   assign base      = exhausted ? lim : bump_pos_ff;
   assign next_pos  = {1'b0, base} + (ADDR_BITS + 1)'(blk);

   // Answers for the command on offer.
   always_comb begin
      rsp.empty       = exhausted && last_slab;
      rsp.grow_reject = (cmd.new_total <= pool_bytes_ff) ||
                        (slab_count_ff == SLAB_CNT_W'(MAX_SLABS));
      rsp.addr        = base;
   end

   // Next state of the slab bookkeeping.
   always_comb begin
      slab_limit_in   = slab_limit_ff;
      slab_count_in   = slab_count_ff;
      current_slab_in = current_slab_ff;
      bump_pos_in     = bump_pos_ff;
      pool_bytes_in   = pool_bytes_ff;
      if (cmd.bump && !rsp.empty) begin
         if (exhausted) begin
            current_slab_in = current_slab_ff + SLAB_IDX_W'(1);
         end
         bump_pos_in = next_pos[ADDR_BITS] ? ADDR_MAX : next_pos[ADDR_BITS-1:0];
      end
      if (cmd.grow && !rsp.grow_reject) begin
         slab_limit_in[slab_count_ff[SLAB_IDX_W-1:0]] = cmd.new_total;
         slab_count_in = slab_count_ff + SLAB_CNT_W'(1);
         pool_bytes_in = cmd.new_total;
      end
   end

   assign start_bytes = reset ? ADDR_BITS'(INITIAL_BYTES_RESET) : ADDR_BITS'(restart_bytes);

   // Slab registers; reset and a new first slab size both restart the pool.
   always_ff @(posedge clock) begin
      if (reset || restart) begin
         for (int i = 0; i < MAX_SLABS; i++) begin
            slab_limit_ff[i] <= (i == 0) ? start_bytes : '0;
         end
         slab_count_ff   <= SLAB_CNT_W'(1);
         current_slab_ff <= '0;
         bump_pos_ff     <= '0;
         pool_bytes_ff   <= start_bytes;
      end else begin
         slab_limit_ff   <= slab_limit_in;
         slab_count_ff   <= slab_count_in;
         current_slab_ff <= current_slab_in;
         bump_pos_ff     <= bump_pos_in;
         pool_bytes_ff   <= pool_bytes_in;
      end
   end

endmodule

[design/fixed_block_pool_allocator.sv]
// Top level of the fixed block pool allocator: request sequencer, free store
// memory and response register. Depends on fbpa_pkg and fbpa_slab.
`timescale 1ns / 1ps

// Every request passes from the idle state to the execute state: in the cycle a
// request is accepted the free store memory (single port, registered read)
// is read at its last live entry, and in the execute state the request is
// executed and its response registered. The first free entry is held in a
// register, so a get that pops the free store needs no second memory access.
// A new request is taken while the previous response still waits on rsp_ready;
// execution then holds until the response register is free. Writing the
// initial_bytes register restarts the pool; block_bytes of zero acts as one.
module fixed_block_pool_allocator (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [fbpa_pkg::OP_W-1:0]        req_op,
   input  logic [fbpa_pkg::ADDR_BITS-1:0]   req_handle,
   input  logic [fbpa_pkg::ADDR_BITS-1:0]   req_new_total,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [fbpa_pkg::STATUS_W-1:0]    rsp_status,
   output logic [fbpa_pkg::ADDR_BITS-1:0]   rsp_block_addr,
   input  logic                             csr_wr_en,
   input  logic [fbpa_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [fbpa_pkg::CSR_DAT_W-1:0]   csr_wdata
);
   import fbpa_pkg::*;

   fsm_state_type         state_ff, state_in;
   logic [OP_W-1:0]       req_op_ff;
   logic [ADDR_BITS-1:0]  req_handle_ff;
   logic [ADDR_BITS-1:0]  req_new_total_ff;
   logic [BLOCK_W-1:0]    block_bytes_ff;
   logic [FREE_CNT_W-1:0] free_count_ff, free_count_in;
   logic [ADDR_BITS-1:0]  head_ff, head_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   status_type            rsp_status_ff, rsp_status_in;
   logic [ADDR_BITS-1:0]  rsp_addr_ff, rsp_addr_in;

   logic [ADDR_BITS-1:0]  free_mem [FREE_DEPTH];
   logic [ADDR_BITS-1:0]  mem_rdata_ff;
   logic                  mem_re;
   logic                  mem_we;
   logic [FREE_IDX_W-1:0] mem_addr;
   logic [FREE_CNT_W-1:0] last_idx;

   logic                  req_fire;
   logic                  out_free;
   logic                  exec;
   logic                  restart;
   slab_cmd_type          slab_cmd;
   slab_rsp_type          slab_rsp;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign exec      = (state_ff == ST_EXEC) && out_free;
   assign restart   = csr_wr_en && (csr_index == CSR_INITIAL_BYTES);

   // Request sequencer state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Request capture.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         req_op_ff        <= req_op;
         req_handle_ff    <= req_handle;
         req_new_total_ff <= req_new_total;
      end
   end

   // Free store: read the last live entry on acceptance, write a put behind the head.
   assign last_idx = free_count_ff - FREE_CNT_W'(1);
   assign mem_re   = req_fire;
   assign mem_we   = exec && (req_op_ff == OP_PUT) && (free_count_ff != '0) &&
                     (free_count_ff != FREE_CNT_W'(FREE_DEPTH));
   assign mem_addr = mem_we ? free_count_ff[FREE_IDX_W-1:0] : last_idx[FREE_IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (mem_we) begin
         free_mem[mem_addr] <= req_handle_ff;
      end
      if (mem_re) begin
         mem_rdata_ff <= free_mem[mem_addr];
      end
   end

   // Slab unit commands.
   always_comb begin
      slab_cmd.bump      = exec && (req_op_ff == OP_GET) && (free_count_ff == '0);
      slab_cmd.grow      = exec && (req_op_ff == OP_GROW);
      slab_cmd.new_total = req_new_total_ff;
   end

   fbpa_slab u_slab (
      .clock         (clock),
      .reset         (reset),
      .restart       (restart),
      .restart_bytes (csr_wdata[INIT_W-1:0]),
      .block_bytes   (block_bytes_ff),
      .cmd           (slab_cmd),
      .rsp           (slab_rsp)
   );

   // Execution of the request and the response it produces.
   always_comb begin
      free_count_in = free_count_ff;
      head_in       = head_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_addr_in   = rsp_addr_ff;
      if (exec) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = STATUS_OK;
         rsp_addr_in   = '0;
         case (req_op_ff)
            OP_GET: begin
               if (free_count_ff != '0) begin
                  // Pop: hand out the head and move the last entry into its place.
                  rsp_addr_in   = head_ff;
                  head_in       = mem_rdata_ff;
                  free_count_in = last_idx;
               end else if (slab_rsp.empty) begin
                  rsp_status_in = STATUS_EMPTY;
               end else begin
                  rsp_addr_in = slab_rsp.addr;
               end
            end
            OP_PUT: begin
               if (free_count_ff == FREE_CNT_W'(FREE_DEPTH)) begin
                  rsp_status_in = STATUS_STORE_FULL;
               end else begin
                  if (free_count_ff == '0) begin
                     head_in = req_handle_ff;
                  end
                  free_count_in = free_count_ff + FREE_CNT_W'(1);
               end
            end
            OP_GROW: begin
               if (slab_rsp.grow_reject) begin
                  rsp_status_in = STATUS_GROW_REJECT;
               end
            end
            default: begin
               rsp_status_in = STATUS_OK;
            end
         endcase
      end
   end

   // Control registers, configuration and free count.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff   <= 1'b0;
         free_count_ff  <= '0;
         block_bytes_ff <= BLOCK_BYTES_RESET;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         free_count_ff <= restart ? '0 : free_count_in;
         if (csr_wr_en && (csr_index == CSR_BLOCK_BYTES)) begin
            block_bytes_ff <= csr_wdata[BLOCK_W-1:0];
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      head_ff       <= head_in;
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_block_addr = rsp_addr_ff;

endmodule
